>>> rtl/mcbw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcbw_pkg
// Types and constants shared by the multi-channel bus watchdog modules.
// ----------------------------------------------------------------------------
package mcbw_pkg;

	// The bus count is tied to the six-bit timeout mask of the result.
	localparam int unsigned NUM_BUSES = 6;
	localparam int unsigned BUS_W     = 3;
	localparam int unsigned OP_W      = 3;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// Operation codes. Codes above OP_QUERY behave as a query.
	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_FEED    = 3'd1;
	localparam logic [OP_W-1:0] OP_ENABLE  = 3'd2;
	localparam logic [OP_W-1:0] OP_DISABLE = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAN_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [BUS_W-1:0] bus_index;
	} req_item_t;

	typedef struct packed {
		logic [NUM_BUSES-1:0] timeout_mask;
		logic                 selected_timed_out;
	} rsp_item_t;

	// Per-channel command, valid for one cycle when a transaction executes.
	typedef struct packed {
		logic tick;
		logic feed;
		logic enable;
		logic stop;
	} chan_cmd_t;

endpackage : mcbw_pkg
`default_nettype wire

>>> rtl/mcbw_channel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcbw_channel
// One auto-reload activity watchdog: enable bit, tick counter and sticky flag.
// ----------------------------------------------------------------------------
module mcbw_channel
	import mcbw_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire chan_cmd_t        cmd,
	input  wire logic [CNT_W-1:0] limit,
	output logic                  flag_next
);

	logic             enabled_q;
	logic             flag_q;
	logic [CNT_W-1:0] count_q;

	logic             enabled_d;
	logic             flag_d;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W:0]   count_inc;
	logic             limit_zero;

	assign limit_zero = (limit == '0);
	assign count_inc  = {1'b0, count_q} + {{CNT_W{1'b0}}, 1'b1};

	always_comb begin
		enabled_d = enabled_q;
		flag_d    = flag_q;
		count_d   = count_q;
		if (cmd.tick) begin
			// A zero limit freezes an enabled channel.
			if (enabled_q && !limit_zero) begin
				if (count_inc >= {1'b0, limit}) begin
					flag_d  = 1'b1;
					count_d = '0;
				end else begin
					count_d = count_inc[CNT_W-1:0];
				end
			end
		end else if (cmd.feed) begin
			if (enabled_q) begin
				flag_d  = 1'b0;
				count_d = '0;
			end
		end else if (cmd.enable) begin
			enabled_d = !limit_zero;
			flag_d    = 1'b0;
			count_d   = '0;
		end else if (cmd.stop) begin
			enabled_d = 1'b0;
			flag_d    = 1'b0;
			count_d   = '0;
		end
	end

	assign flag_next = flag_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			flag_q    <= 1'b0;
			count_q   <= '0;
		end else begin
			enabled_q <= enabled_d;
			flag_q    <= flag_d;
			count_q   <= count_d;
		end
	end

endmodule : mcbw_channel
`default_nettype wire

>>> rtl/multi_channel_bus_watchdog_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_bus_watchdog_core
// Six bus-activity watchdogs with tick, feed, enable, disable and query.
// ----------------------------------------------------------------------------
// Each transaction passes through two register stages: it is captured in an
// input register, then executed against all channels while the result is
// loaded into the output register; one transaction is accepted every cycle
// as long as the consumer takes results. A tick advances every enabled
// channel in parallel; the compare of each 16-bit counter against its
// timeout sets the cycle time. Buses below NUM_CAN_BUSES use the CAN
// timeout register and the others use the LIN timeout register. A timeout
// of zero keeps a bus from being enabled and freezes a bus that is already
// enabled. Timeout registers must be written only while no transaction is
// in flight. The result carries the mask of all timed-out flags and the
// flag of the selected bus, both taken after the operation; bus numbers
// beyond the last bus are ignored and report zero.
// ----------------------------------------------------------------------------
module multi_channel_bus_watchdog_core
	import mcbw_pkg::*;
#(
	parameter int unsigned NUM_CAN_BUSES = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Configuration write port.
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_wdata,
	// Request channel.
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire req_item_t            req,
	// Response channel.
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output rsp_item_t                 rsp
);

	// Timeout registers.
	logic [CNT_W-1:0] can_timeout_q;
	logic [CNT_W-1:0] lin_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			can_timeout_q <= '0;
			lin_timeout_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAN_TIMEOUT: can_timeout_q <= cfg_wdata;
				REG_LIN_TIMEOUT: lin_timeout_q <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// Stage 1 holds the accepted transaction. It moves on whenever the output
	// register is empty or is being emptied in the same cycle.
	logic      valid_s1;
	req_item_t item_s1;
	logic      out_free;
	logic      exec;

	assign out_free  = !rsp_valid || !rsp_stall;
	assign exec      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	// Decode the transaction into per-channel commands. A tick ignores the
	// bus number; other operations reach only an in-range selected bus.
	logic      bus_in_range;
	chan_cmd_t bus_cmd;
	chan_cmd_t tick_cmd;

	assign bus_in_range = ({1'b0, item_s1.bus_index} < (BUS_W + 1)'(NUM_BUSES));

	always_comb begin
		bus_cmd  = '0;
		tick_cmd = '0;
		if (exec) begin
			unique case (item_s1.opcode)
				OP_TICK:    tick_cmd.tick  = 1'b1;
				OP_FEED:    bus_cmd.feed   = bus_in_range;
				OP_ENABLE:  bus_cmd.enable = bus_in_range;
				OP_DISABLE: bus_cmd.stop   = bus_in_range;
				default:    ;
			endcase
		end
	end

	// Channel array.
	logic [NUM_BUSES-1:0] flag_next;

	for (genvar i = 0; i < NUM_BUSES; i++) begin : g_chan
		chan_cmd_t        cmd;
		logic [CNT_W-1:0] limit;

		assign limit = (i < NUM_CAN_BUSES) ? can_timeout_q : lin_timeout_q;
		assign cmd   = (item_s1.bus_index == BUS_W'(i)) ? (bus_cmd | tick_cmd) : tick_cmd;

		mcbw_channel u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.limit     (limit),
			.flag_next (flag_next[i])
		);
	end

	// Output register: loaded with the post-operation flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_free) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsp.timeout_mask       <= flag_next;
			rsp.selected_timed_out <= bus_in_range
				&& flag_next[item_s1.bus_index];
		end
	end

endmodule : multi_channel_bus_watchdog_core
`default_nettype wire

>>> tb/sv/tb_multi_channel_bus_watchdog_core.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_bus_watchdog_core
// Self-checking bench for the six-channel bus watchdog: a scoreboard keeps its
// own copy of the counters, enables and timed-out flags, predicts the result
// of every accepted request and compares it with the response, while both
// channels idle and stall at random across several timeout settings.
// ----------------------------------------------------------------------------
import mcbw_pkg::*;

class watchdog_scoreboard;
	int unsigned    can_buses;
	bit [CNT_W-1:0] can_limit;
	bit [CNT_W-1:0] lin_limit;
	bit [CNT_W-1:0] elapsed [NUM_BUSES];
	bit             armed   [NUM_BUSES];
	bit             tripped [NUM_BUSES];
	rsp_item_t      expected_rsp [$];
	int             errors;

	function new(int unsigned n_can);
		can_buses = n_can;
		can_limit = '0;
		lin_limit = '0;
		errors    = 0;
		foreach (elapsed[i]) begin
			elapsed[i] = '0;
			armed[i]   = 1'b0;
			tripped[i] = 1'b0;
		end
	endfunction

	function bit [CNT_W-1:0] limit_for(int unsigned bus);
		return (bus < can_buses) ? can_limit : lin_limit;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
		if (idx == REG_CAN_TIMEOUT)
			can_limit = val;
		else
			lin_limit = val;
	endfunction

	// One millisecond tick: every enabled channel with a nonzero timeout
	// counts, and trips and reloads once it reaches or passes its timeout.
	function void advance_all();
		bit [CNT_W:0] next_count;
		for (int unsigned i = 0; i < NUM_BUSES; i++) begin
			if (armed[i] && limit_for(i) != '0) begin
				next_count = {1'b0, elapsed[i]} + (CNT_W + 1)'(1);
				if (next_count >= {1'b0, limit_for(i)}) begin
					tripped[i] = 1'b1;
					elapsed[i] = '0;
				end else begin
					elapsed[i] = next_count[CNT_W-1:0];
				end
			end
		end
	endfunction

	function void log_request(req_item_t item);
		int unsigned bus;
		bit          in_range;
		rsp_item_t   result;
		bus      = 32'(item.bus_index);
		in_range = (bus < NUM_BUSES);
		if (item.opcode == OP_TICK) begin
			advance_all();
		end else if (in_range) begin
			case (item.opcode)
				OP_FEED: begin
					if (armed[bus]) begin
						tripped[bus] = 1'b0;
						elapsed[bus] = '0;
					end
				end
				OP_ENABLE: begin
					armed[bus]   = (limit_for(bus) != '0);
					tripped[bus] = 1'b0;
					elapsed[bus] = '0;
				end
				OP_DISABLE: begin
					armed[bus]   = 1'b0;
					tripped[bus] = 1'b0;
					elapsed[bus] = '0;
				end
				default: ;
			endcase
		end
		result.timeout_mask = '0;
		for (int unsigned i = 0; i < NUM_BUSES; i++)
			result.timeout_mask[i] = tripped[i];
		result.selected_timed_out = in_range ? tripped[bus] : 1'b0;
		expected_rsp.push_back(result);
	endfunction

	function void check_response(rsp_item_t got);
		rsp_item_t want;
		if (expected_rsp.size() == 0) begin
			$error("response with no request outstanding: timeout_mask %0h", got.timeout_mask);
			errors++;
			return;
		end
		want = expected_rsp.pop_front();
		if (got.timeout_mask !== want.timeout_mask) begin
			$error("timeout_mask: expected %0h, got %0h", want.timeout_mask, got.timeout_mask);
			errors++;
		end
		if (got.selected_timed_out !== want.selected_timed_out) begin
			$error("selected_timed_out: expected %0b, got %0b",
				want.selected_timed_out, got.selected_timed_out);
			errors++;
		end
	endfunction

	function int pending();
		return expected_rsp.size();
	endfunction
endclass

module tb_multi_channel_bus_watchdog_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAN_BUSES      = 2;
	localparam int unsigned CLK_PERIOD     = 20;
	localparam int unsigned ITEMS_PER_PLAN = 235;
	localparam int unsigned PLAN_COUNT     = 8;
	// Simulation time limit, several times the slowest legal run.
	localparam longint unsigned RUN_LIMIT_NS = 64'd8_000_000;
	// Opcodes above the query code are undefined and behave as a query.
	localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_wdata;
	logic                 req_valid;
	logic                 req_stall;
	req_item_t            req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_item_t            rsp;

	// Burst flags switch each side between random idling and back-to-back
	// transactions, so that long stretches without gaps also occur.
	bit send_burst;
	bit take_burst;

	watchdog_scoreboard sb = new(CAN_BUSES);

	multi_channel_bus_watchdog_core #(
		.NUM_CAN_BUSES(CAN_BUSES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Every response transaction is checked at the edge that accepts it. The
	// values seen here are those from before the edge, since the block and
	// the bench both update their signals with nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// Response side: before each response it stalls for a random number of
	// cycles, then stays ready until one transaction has been accepted.
	initial begin
		int unsigned hold;
		take_burst = 1'b0;
		forever begin
			if ($urandom_range(0, 19) == 0)
				take_burst = !take_burst;
			hold = take_burst ? 0 : $urandom_range(0, 12);
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!(arst_n === 1'b1 && rsp_valid))
				@(posedge clk);
		end
	end

	// Presents one request after a random gap and holds it until accepted.
	// It is always entered at a rising edge and returns at the accepting
	// edge, so req_valid never gets two assignments in one time step.
	task automatic send_request(req_item_t item);
		int unsigned gap;
		if ($urandom_range(0, 19) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.log_request(item);
	endtask

	task automatic issue(logic [OP_W-1:0] op, logic [BUS_W-1:0] bus);
		req_item_t item;
		item.opcode    = op;
		item.bus_index = bus;
		send_request(item);
	endtask

	// Mostly operations on real buses with plenty of ticks so that channels
	// actually time out; a small share goes to absent buses and to the
	// undefined opcodes.
	function automatic req_item_t random_request();
		req_item_t   item;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			item.opcode = OP_TICK;
		else if (pick < 60)
			item.opcode = OP_FEED;
		else if (pick < 75)
			item.opcode = OP_ENABLE;
		else if (pick < 82)
			item.opcode = OP_DISABLE;
		else if (pick < 93)
			item.opcode = OP_QUERY;
		else
			item.opcode = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
		if ($urandom_range(0, 9) == 0)
			item.bus_index = BUS_W'($urandom_range(NUM_BUSES, 7));
		else
			item.bus_index = BUS_W'($urandom_range(0, NUM_BUSES - 1));
		return item;
	endfunction

	// Stops sending and waits until every expected response has come back,
	// then waits for the two register stages of the block to empty.
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes the CAN timeout register, then the LIN one. The block must
	// be idle, so this is only called right after drain.
	task automatic program_timeouts(logic [CNT_W-1:0] can_ms, logic [CNT_W-1:0] lin_ms);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CAN_TIMEOUT;
		cfg_wdata <= can_ms;
		@(posedge clk);
		sb.write_reg(REG_CAN_TIMEOUT, can_ms);
		cfg_index <= REG_LIN_TIMEOUT;
		cfg_wdata <= lin_ms;
		@(posedge clk);
		sb.write_reg(REG_LIN_TIMEOUT, lin_ms);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [CNT_W-1:0] can_plan [PLAN_COUNT];
		logic [CNT_W-1:0] lin_plan [PLAN_COUNT];
		// The plans cover zero, one and the largest timeout on both registers.
		// Counts left over from a long timeout run into a short one, which
		// checks a timeout lowered below the count; a zero after a nonzero
		// timeout freezes channels that are still enabled.
		can_plan = '{16'd3, 16'd65535, 16'd2, 16'd0, 16'd1, 16'd7, 16'd65535, 16'd4};
		lin_plan = '{16'd5, 16'd4, 16'd0, 16'd6, 16'd65535, 16'd3, 16'd65535, 16'd1};
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= REG_CAN_TIMEOUT;
		cfg_wdata  <= '0;
		req_valid  <= 1'b0;
		req        <= '0;
		send_burst = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both timeouts are still zero after reset: enabling must not arm a
		// channel, ticks change nothing, and feeding a disabled bus is a no-op.
		// Absent buses and undefined opcodes report a clear selected flag.
		issue(OP_ENABLE, 3'd0);
		issue(OP_ENABLE, 3'd5);
		issue(OP_TICK, 3'd0);
		issue(OP_FEED, 3'd3);
		issue(OP_QUERY, 3'd6);
		issue(OP_RESERVED_LAST, 3'd7);
		drain();

		// Shortest timeouts: LIN buses trip on the first tick, CAN buses on
		// the second. Feed, disable and undefined opcodes are then applied to
		// tripped buses, and commands to absent buses must be ignored.
		program_timeouts(16'd2, 16'd1);
		for (int b = 0; b < NUM_BUSES; b++)
			issue(OP_ENABLE, b[BUS_W-1:0]);
		issue(OP_ENABLE, 3'd6);
		issue(OP_TICK, 3'd7);
		issue(OP_TICK, 3'd0);
		issue(OP_QUERY, 3'd1);
		issue(OP_FEED, 3'd0);
		issue(OP_FEED, 3'd7);
		issue(OP_DISABLE, 3'd2);
		issue(OP_QUERY, 3'd2);
		issue(OP_RESERVED_FIRST, 3'd3);
		issue(OP_RESERVED_FIRST + 3'd1, 3'd4);
		issue(OP_TICK, 3'd0);
		issue(OP_DISABLE, 3'd7);
		issue(OP_TICK, 3'd5);

		// Random traffic under each timeout plan. Every change of plan first
		// lets the block run dry, which also exercises a paused sender.
		for (int p = 0; p < PLAN_COUNT; p++) begin
			drain();
			program_timeouts(can_plan[p], lin_plan[p]);
			repeat (ITEMS_PER_PLAN)
				send_request(random_request());
		end
		drain();

		if (sb.pending() != 0) begin
			$error("%0d expected responses never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("[multi_channel_bus_watchdog_core] OK");
		else
			$display("[multi_channel_bus_watchdog_core] ERROR");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("[multi_channel_bus_watchdog_core] ERROR");
		$finish;
	end
endmodule
